// ===== rtl/core/isas_pkg.sv =====
// ----------------------------------------------------------------------------
// isas_pkg
// Shared types, constants and the structure form decode for the
// interleaved structure access sequencer.
// ----------------------------------------------------------------------------
package isas_pkg;

  // number of doubleword registers in the register file (16 to 32)
  localparam int NUM_DREGS = 32;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNDEF  = 2'd1;
  localparam logic [1:0] ST_UNPRED = 2'd2;

  // structure form type codes
  localparam logic [3:0] TY_1R1  = 4'b0111;
  localparam logic [3:0] TY_1R2  = 4'b1010;
  localparam logic [3:0] TY_1R3  = 4'b0110;
  localparam logic [3:0] TY_1R4  = 4'b0010;
  localparam logic [3:0] TY_2I1  = 4'b1000;
  localparam logic [3:0] TY_2I2  = 4'b1001;
  localparam logic [3:0] TY_2R2  = 4'b0011;
  localparam logic [3:0] TY_3I1  = 4'b0100;
  localparam logic [3:0] TY_3I2  = 4'b0101;
  localparam logic [3:0] TY_4I1  = 4'b0000;
  localparam logic [3:0] TY_4I2  = 4'b0001;

  localparam logic [1:0] SIZE_DW  = 2'b11;
  localparam logic [1:0] ALIGN_HI = 2'b11;

  // general register codes with special writeback meaning
  localparam logic [3:0] REG_PC = 4'd15;
  localparam logic [3:0] REG_SP = 4'd13;

  typedef struct packed {
    logic       valid;
    logic [1:0] nelem_m1;
    logic [1:0] regs_m1;
    logic [1:0] inc;
  } dec_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

  function automatic dec_t decode_form(input logic [3:0] ty, input logic [1:0] sz,
                                       input logic [1:0] al);
    dec_t d;
    logic sz_ok;
    logic al3;
    sz_ok = (sz != SIZE_DW);
    al3   = (al == ALIGN_HI);
    d     = '0;
    case (ty)
      TY_1R1: begin d = '{!al[1], 2'd0, 2'd0, 2'd0}; end
      TY_1R2: begin d = '{!al3, 2'd0, 2'd1, 2'd0}; end
      TY_1R3: begin d = '{!al[1], 2'd0, 2'd2, 2'd0}; end
      TY_1R4: begin d = '{1'b1, 2'd0, 2'd3, 2'd0}; end
      TY_2I1: begin d = '{sz_ok && !al3, 2'd1, 2'd0, 2'd1}; end
      TY_2I2: begin d = '{sz_ok && !al3, 2'd1, 2'd0, 2'd2}; end
      TY_2R2: begin d = '{sz_ok, 2'd1, 2'd1, 2'd2}; end
      TY_3I1: begin d = '{sz_ok && !al[1], 2'd2, 2'd0, 2'd1}; end
      TY_3I2: begin d = '{sz_ok && !al[1], 2'd2, 2'd0, 2'd2}; end
      TY_4I1: begin d = '{sz_ok, 2'd3, 2'd0, 2'd1}; end
      TY_4I2: begin d = '{sz_ok, 2'd3, 2'd0, 2'd2}; end
      default: begin d = '{1'b0, 2'd0, 2'd0, 2'd0}; end
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/isas_ctrl.sv =====
// ----------------------------------------------------------------------------
// isas_ctrl
// Sequencer control: waits for an instruction, then steps the datapath
// once a cycle until the final access has been issued.
// ----------------------------------------------------------------------------
module isas_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  isas_pkg::dp_sts_t  sts,
  output isas_pkg::ctl_cmd_t cmd,
  output logic               busy,
  output logic               issue
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy  = (state_r == S_RUN);
  assign issue = (state_r == S_RUN);

endmodule

// ===== rtl/core/isas_datapath.sv =====
// ----------------------------------------------------------------------------
// isas_datapath
// Decoded instruction registers, register/lane/member counters and the
// running address; forms each element access from them.
// ----------------------------------------------------------------------------
module isas_datapath (
  input  logic               clk,
  input  isas_pkg::ctl_cmd_t cmd,
  input  logic               in_func,
  input  logic               in_d_high,
  input  logic [3:0]         in_vd,
  input  logic [3:0]         in_type_code,
  input  logic [1:0]         in_size_code,
  input  logic [1:0]         in_align_code,
  input  logic [3:0]         in_base_reg,
  input  logic [3:0]         in_index_reg,
  input  logic [31:0]        in_base_value,
  input  logic [31:0]        in_index_value,
  output isas_pkg::dp_sts_t  sts,
  output logic [1:0]         out_status,
  output logic [31:0]        out_access_address,
  output logic [4:0]         out_ext_reg,
  output logic [2:0]         out_lane,
  output logic [3:0]         out_access_bytes,
  output logic               out_is_read,
  output logic               out_writeback_en,
  output logic [31:0]        out_writeback_value,
  output logic               out_last
);

  logic        func_r;
  logic [4:0]  first_r;
  logic [1:0]  size_r;
  logic [1:0]  nelem_m1_r;
  logic [1:0]  regs_m1_r;
  logic [1:0]  inc_r;
  logic [2:0]  elem_m1_r;
  logic [1:0]  status_r;
  logic [31:0] addr_r;
  logic        wb_en_r;
  logic [31:0] wb_val_r;
  logic [1:0]  r_r;
  logic [2:0]  e_r;
  logic [1:0]  i_r;

  isas_pkg::dec_t dec;
  logic [4:0]  first;
  logic [6:0]  span;
  logic [5:0]  xfer_len;
  logic [1:0]  status_nxt;
  logic        ok;
  logic        i_end;
  logic        e_end;
  logic        r_end;
  logic [3:0]  ebytes;

  always_comb begin
    dec   = isas_pkg::decode_form(in_type_code, in_size_code, in_align_code);
    first = {in_d_high, in_vd};
    // highest register touched plus one
    span  = 7'(first) + (7'(dec.inc) * 7'(dec.nelem_m1)) + 7'(dec.regs_m1) + 7'd1;
    xfer_len = {(3'(dec.nelem_m1) + 3'd1) * (3'(dec.regs_m1) + 3'd1), 3'b000};
    if (!dec.valid) begin
      status_nxt = isas_pkg::ST_UNDEF;
    end else if (in_base_reg == isas_pkg::REG_PC || span > 7'(isas_pkg::NUM_DREGS)) begin
      status_nxt = isas_pkg::ST_UNPRED;
    end else begin
      status_nxt = isas_pkg::ST_OK;
    end
  end

  assign ok     = (status_r == isas_pkg::ST_OK);
  assign i_end  = (i_r == nelem_m1_r);
  assign e_end  = (e_r == elem_m1_r);
  assign r_end  = (r_r == regs_m1_r);
  assign ebytes = 4'd1 << size_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r     <= in_func;
      first_r    <= first;
      size_r     <= in_size_code;
      nelem_m1_r <= dec.nelem_m1;
      regs_m1_r  <= dec.regs_m1;
      inc_r      <= dec.inc;
      elem_m1_r  <= 3'd7 >> in_size_code;
      status_r   <= status_nxt;
      addr_r     <= in_base_value;
      wb_en_r    <= (in_index_reg != isas_pkg::REG_PC);
      wb_val_r   <= in_base_value + ((in_index_reg == isas_pkg::REG_SP) ?
                                     32'(xfer_len) : in_index_value);
      r_r        <= '0;
      e_r        <= '0;
      i_r        <= '0;
    end else if (cmd.step) begin
      addr_r <= addr_r + 32'(ebytes);
      if (!i_end) begin
        i_r <= i_r + 2'd1;
      end else begin
        i_r <= '0;
        if (!e_end) begin
          e_r <= e_r + 3'd1;
        end else begin
          e_r <= '0;
          r_r <= r_r + 2'd1;
        end
      end
    end
  end

  assign sts.last = !ok || (i_end && e_end && r_end);

  assign out_status          = status_r;
  assign out_access_address  = ok ? addr_r : '0;
  assign out_ext_reg         = ok ? (first_r + (5'(i_r) * 5'(inc_r)) + 5'(r_r)) : '0;
  assign out_lane            = ok ? e_r : '0;
  assign out_access_bytes    = ok ? ebytes : '0;
  assign out_is_read         = ok && func_r;
  assign out_writeback_en    = ok && sts.last && wb_en_r;
  assign out_writeback_value = out_writeback_en ? wb_val_r : '0;
  assign out_last            = sts.last;

endmodule

// ===== rtl/core/interleaved_structure_access_sequencer.sv =====
// ----------------------------------------------------------------------------
// interleaved_structure_access_sequencer
// Decodes one multiple-structure vector load/store and issues its element
// accesses in memory order, one per cycle, with the base writeback on the last.
// ----------------------------------------------------------------------------
// order: first result in the cycle after start is taken, then one per cycle
// instructions: N = 1 to 32 accesses each (regs*lanes*members); start is taken only when idle
// the access counters in the datapath set N and the last access; the receiver cannot stall
// reset: synchronous active-low rst_n returns the controller to idle
module interleaved_structure_access_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic        in_d_high,
  input  logic [3:0]  in_vd,
  input  logic [3:0]  in_type_code,
  input  logic [1:0]  in_size_code,
  input  logic [1:0]  in_align_code,
  input  logic [3:0]  in_base_reg,
  input  logic [3:0]  in_index_reg,
  input  logic [31:0] in_base_value,
  input  logic [31:0] in_index_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_access_address,
  output logic [4:0]  out_ext_reg,
  output logic [2:0]  out_lane,
  output logic [3:0]  out_access_bytes,
  output logic        out_is_read,
  output logic        out_writeback_en,
  output logic [31:0] out_writeback_value,
  output logic        out_last
);

  isas_pkg::ctl_cmd_t cmd;
  isas_pkg::dp_sts_t  sts;

  isas_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .issue (out_valid)
  );

  isas_datapath u_dp (
    .clk                 (clk),
    .cmd                 (cmd),
    .in_func             (in_func),
    .in_d_high           (in_d_high),
    .in_vd               (in_vd),
    .in_type_code        (in_type_code),
    .in_size_code        (in_size_code),
    .in_align_code       (in_align_code),
    .in_base_reg         (in_base_reg),
    .in_index_reg        (in_index_reg),
    .in_base_value       (in_base_value),
    .in_index_value      (in_index_value),
    .sts                 (sts),
    .out_status          (out_status),
    .out_access_address  (out_access_address),
    .out_ext_reg         (out_ext_reg),
    .out_lane            (out_lane),
    .out_access_bytes    (out_access_bytes),
    .out_is_read         (out_is_read),
    .out_writeback_en    (out_writeback_en),
    .out_writeback_value (out_writeback_value),
    .out_last            (out_last)
  );

  a_start_issues: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted item produced no result");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != isas_pkg::ST_OK) |-> out_last)
    else $error("error result not final");

  a_wb_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_writeback_en) |-> out_last)
    else $error("writeback on non-final result");

  a_run_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> (out_valid && $stable(out_is_read)))
    else $error("access run broken before final result");

endmodule
